@@ rtl/vlmf_pkg.sv @@
// ----------------------------------------------------------------------------
// vlmf_pkg
// Shared sizes, codes and word types of the variable-length message queue.
// ----------------------------------------------------------------------------
package vlmf_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int HEADER_SLOTS = 16;

  localparam int PTR_W   = $clog2(BUFFER_BYTES);
  localparam int SLOT_W  = $clog2(HEADER_SLOTS);
  localparam int COUNT_W = $clog2(HEADER_SLOTS + 1);
  localparam int FREE_W  = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W   = 11;
  localparam int CMP_W   = (FREE_W > LEN_W) ? FREE_W : LEN_W;
  localparam int POS_W   = CMP_W + 1;

  localparam logic [2:0] CMD_PUT_START = 3'd0;
  localparam logic [2:0] CMD_PUT_BYTE  = 3'd1;
  localparam logic [2:0] CMD_GET_BYTE  = 3'd2;
  localparam logic [2:0] CMD_PEEK      = 3'd3;
  localparam logic [2:0] CMD_ERASE     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_SEQUENCE = 2'd3;

  typedef struct packed {
    logic [2:0]       command;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       read_byte;
    logic             last_byte;
    logic [LEN_W-1:0] oldest_length;
    logic [4:0]       message_count;
    logic [10:0]      bytes_free;
  } result_t;

  typedef struct packed {
    logic [PTR_W-1:0] start;
    logic [LEN_W-1:0] length;
  } slot_entry_t;

endpackage

@@ rtl/vlmf_byte_store.sv @@
// ----------------------------------------------------------------------------
// vlmf_byte_store
// Circular message byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vlmf_byte_store
  import vlmf_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [PTR_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/vlmf_slot_table.sv @@
// ----------------------------------------------------------------------------
// vlmf_slot_table
// Descriptor ring: start and length of each queued message.
// ----------------------------------------------------------------------------
module vlmf_slot_table
  import vlmf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [HEADER_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/variable_length_message_fifo_top.sv @@
// ----------------------------------------------------------------------------
// variable_length_message_fifo_top
// FIFO of variable-length byte messages over a circular byte store.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start while busy is low; the word is taken at
// that edge. Commands: put start reserves message_length bytes, put byte
// writes the next byte, get byte hands out the next byte of the oldest
// message, peek reports the oldest length, erase empties the queue.
// Each word produces exactly one result word, shown on result for one cycle
// with done high; the receiver cannot hold it off.
// Timing: the slot and byte memories are read at the accept edge and their
// data is used in the following cycle, so result and done are registered at
// the end of the execute state that follows accept. A get byte that opens a
// message first passes through a fetch state, since the byte address comes
// out of the slot memory first. A new word is taken only after the last one
// has produced its result; busy stays high in between.
// Reset empties the queue and frees the whole store; memory contents are
// left as they are, since only written entries are ever read.
// ----------------------------------------------------------------------------
module variable_length_message_fifo_top
  import vlmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state;
  item_t  req;

  // Queue state
  logic [SLOT_W-1:0]  newest_slot, newest_slot_next;
  logic [SLOT_W-1:0]  oldest_slot, oldest_slot_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [FREE_W-1:0]  free_bytes, free_bytes_next;
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [LEN_W-1:0]   put_remaining, put_remaining_next;
  logic               put_active, put_active_next;
  logic [PTR_W-1:0]   put_start_pos, put_start_pos_next;
  logic [LEN_W-1:0]   put_length, put_length_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [LEN_W-1:0]   read_remaining, read_remaining_next;
  logic               read_active, read_active_next;
  logic [LEN_W-1:0]   read_len;
  result_t            result_next;

  // Memory ports
  logic              slot_wr_en, slot_rd_en;
  logic [SLOT_W-1:0] slot_wr_addr, slot_rd_addr;
  slot_entry_t       slot_wr_data, slot_q;
  logic              byte_wr_en, byte_rd_en;
  logic [PTR_W-1:0]  byte_rd_addr;
  logic [7:0]        byte_q;

  logic accept;
  logic opens_read;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign opens_read = (item.command == CMD_GET_BYTE) && !read_active && (count != '0);

  function automatic logic [SLOT_W-1:0] slot_before(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(HEADER_SLOTS - 1) : s - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] byte_after(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Read at accept: newest descriptor for put start, oldest otherwise
  assign slot_rd_en   = accept;
  assign slot_rd_addr = (item.command == CMD_PUT_START) ? newest_slot : oldest_slot;
  assign byte_rd_en   = accept || (state == S_FETCH);
  assign byte_rd_addr = (state == S_FETCH) ? slot_q.start : read_pointer;

  vlmf_slot_table u_slot_table (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_q)
  );

  vlmf_byte_store u_byte_store (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (write_pointer),
    .wr_data (req.data_byte),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_q)
  );

  always_comb begin
    logic              commit;
    logic              release_msg;
    logic [POS_W-1:0]  pos_sum;
    logic [CMP_W:0]    free_sum;
    logic [LEN_W-1:0]  rem_dec;
    logic [1:0]        status;
    logic [7:0]        rbyte;
    logic              last;
    logic [LEN_W-1:0]  olen;

    newest_slot_next    = newest_slot;
    oldest_slot_next    = oldest_slot;
    count_next          = count;
    free_bytes_next     = free_bytes;
    write_pointer_next  = write_pointer;
    put_remaining_next  = put_remaining;
    put_active_next     = put_active;
    put_start_pos_next  = put_start_pos;
    put_length_next     = put_length;
    read_pointer_next   = read_pointer;
    read_remaining_next = read_remaining;
    read_active_next    = read_active;
    commit       = 1'b0;
    release_msg  = 1'b0;
    byte_wr_en   = 1'b0;
    status       = ST_OK;
    rbyte        = '0;
    last         = 1'b0;
    olen         = '0;
    pos_sum      = POS_W'(slot_q.start) + POS_W'(BUFFER_BYTES) - POS_W'(req.message_length);
    if (pos_sum >= POS_W'(BUFFER_BYTES)) begin
      pos_sum = pos_sum - POS_W'(BUFFER_BYTES);
    end
    rem_dec      = '0;
    free_sum     = '0;

    case (req.command)
      CMD_PUT_START: begin
        if (put_active) begin
          status = ST_SEQUENCE;
        end else if (count >= COUNT_W'(HEADER_SLOTS) ||
                     CMP_W'(free_bytes) < CMP_W'(req.message_length)) begin
          status = ST_NO_SPACE;
        end else begin
          put_start_pos_next = (count == '0) ? '0 : PTR_W'(pos_sum);
          put_length_next    = req.message_length;
          free_bytes_next    = free_bytes - FREE_W'(req.message_length);
          write_pointer_next = put_start_pos_next;
          put_remaining_next = req.message_length;
          put_active_next    = 1'b1;
          commit             = (req.message_length == '0);
        end
      end
      CMD_PUT_BYTE: begin
        if (!put_active) begin
          status = ST_SEQUENCE;
        end else begin
          byte_wr_en         = 1'b1;
          write_pointer_next = byte_after(write_pointer);
          rem_dec = (put_remaining != '0) ? put_remaining - 1'b1 : '0;
          put_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            last   = 1'b1;
            commit = 1'b1;
          end
        end
      end
      CMD_GET_BYTE: begin
        // A message being read was opened in the fetch cycle
        if (!read_active) begin
          status = ST_EMPTY;
        end else begin
          olen = read_len;
          if (read_remaining == '0) begin
            last        = 1'b1;
            release_msg = 1'b1;
          end else begin
            rbyte               = byte_q;
            read_pointer_next   = byte_after(read_pointer);
            rem_dec             = read_remaining - 1'b1;
            read_remaining_next = rem_dec;
            if (rem_dec == '0) begin
              last        = 1'b1;
              release_msg = 1'b1;
            end
          end
        end
      end
      CMD_PEEK: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          olen = slot_q.length;
        end
      end
      CMD_ERASE: begin
        newest_slot_next    = '0;
        oldest_slot_next    = '0;
        count_next          = '0;
        free_bytes_next     = FREE_W'(BUFFER_BYTES);
        write_pointer_next  = '0;
        put_remaining_next  = '0;
        put_active_next     = 1'b0;
        read_pointer_next   = '0;
        read_remaining_next = '0;
        read_active_next    = 1'b0;
      end
      default: begin
        status = ST_SEQUENCE;
      end
    endcase

    // Commit the finished put into the slot just below the newest one, or slot 0 when the queue is empty
    slot_wr_addr = '0;
    if (commit) begin
      if (count == '0) begin
        newest_slot_next = '0;
        oldest_slot_next = '0;
        slot_wr_addr     = '0;
      end else begin
        newest_slot_next = slot_before(newest_slot);
        slot_wr_addr     = newest_slot_next;
      end
      count_next         = count + 1'b1;
      put_active_next    = 1'b0;
      put_remaining_next = '0;
    end
    slot_wr_data.start  = put_start_pos_next;
    slot_wr_data.length = put_length_next;
    slot_wr_en          = (state == S_EXEC) && commit;
    byte_wr_en          = (state == S_EXEC) && byte_wr_en;

    // Release the oldest message and return its bytes
    if (release_msg) begin
      free_sum = (CMP_W + 1)'(free_bytes) + (CMP_W + 1)'(read_len);
      if (free_sum > (CMP_W + 1)'(BUFFER_BYTES)) begin
        free_sum = (CMP_W + 1)'(BUFFER_BYTES);
      end
      free_bytes_next = FREE_W'(free_sum);
      count_next      = (count != '0) ? count - 1'b1 : '0;
      if (count_next == '0) begin
        newest_slot_next = '0;
        oldest_slot_next = '0;
      end else begin
        oldest_slot_next = slot_before(oldest_slot);
      end
      read_active_next    = 1'b0;
      read_remaining_next = '0;
    end

    result_next.status        = status;
    result_next.read_byte     = rbyte;
    result_next.last_byte     = last;
    result_next.oldest_length = olen;
    result_next.message_count = 5'(count_next);
    result_next.bytes_free    = 11'(free_bytes_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      newest_slot    <= '0;
      oldest_slot    <= '0;
      count          <= '0;
      free_bytes     <= FREE_W'(BUFFER_BYTES);
      write_pointer  <= '0;
      put_remaining  <= '0;
      put_active     <= 1'b0;
      read_pointer   <= '0;
      read_remaining <= '0;
      read_active    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= item;
            state <= opens_read ? S_FETCH : S_EXEC;
          end
        end
        S_FETCH: begin
          // Open the oldest message; its first byte is being read now
          read_pointer   <= slot_q.start;
          read_remaining <= slot_q.length;
          read_len       <= slot_q.length;
          read_active    <= 1'b1;
          state          <= S_EXEC;
        end
        S_EXEC: begin
          newest_slot    <= newest_slot_next;
          oldest_slot    <= oldest_slot_next;
          count          <= count_next;
          free_bytes     <= free_bytes_next;
          write_pointer  <= write_pointer_next;
          put_remaining  <= put_remaining_next;
          put_active     <= put_active_next;
          put_start_pos  <= put_start_pos_next;
          put_length     <= put_length_next;
          read_pointer   <= read_pointer_next;
          read_remaining <= read_remaining_next;
          read_active    <= read_active_next;
          result         <= result_next;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/variable_length_message_fifo_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_length_message_fifo_top_tb
// Self-checking bench for the variable-length message queue. A behavioral
// mirror of the queue predicts one result word per accepted command word, and
// every done strobe is checked field by field against the oldest prediction.
// A short directed run covers the corner cases. A random run follows, made
// mostly of whole messages with random bytes, with stray and broken words
// mixed in.
// ----------------------------------------------------------------------------
module variable_length_message_fifo_top_tb;
  import vlmf_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1500;
  localparam int MAX_PRINTED = 40;

  class msg_fifo_scoreboard;
    logic [7:0]         store_bytes [BUFFER_BYTES];
    logic [PTR_W-1:0]   slot_pos [HEADER_SLOTS];
    logic [LEN_W-1:0]   slot_len [HEADER_SLOTS];
    logic [SLOT_W-1:0]  head_slot, tail_slot;
    logic [COUNT_W-1:0] msg_count;
    logic [FREE_W-1:0]  free_cnt;
    logic [PTR_W-1:0]   wr_ptr, wr_base, rd_ptr;
    logic [LEN_W-1:0]   wr_left, wr_len, rd_left;
    bit                 wr_open, rd_open;
    result_t            pending_results [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      for (int i = 0; i < BUFFER_BYTES; i++) store_bytes[i] = '0;
      for (int i = 0; i < HEADER_SLOTS; i++) begin
        slot_pos[i] = '0;
        slot_len[i] = '0;
      end
      head_slot = '0;
      tail_slot = '0;
      msg_count = '0;
      free_cnt = FREE_W'(BUFFER_BYTES);
      wr_ptr = '0;
      wr_base = '0;
      rd_ptr = '0;
      wr_left = '0;
      wr_len = '0;
      rd_left = '0;
      wr_open = 1'b0;
      rd_open = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Slots are handed out downward around the ring.
    function logic [SLOT_W-1:0] prev_slot(logic [SLOT_W-1:0] s);
      return (s == 0) ? SLOT_W'(HEADER_SLOTS - 1) : s - 1'b1;
    endfunction

    function logic [PTR_W-1:0] next_pos(logic [PTR_W-1:0] p);
      return (int'(p) + 1 >= BUFFER_BYTES) ? '0 : p + 1'b1;
    endfunction

    function void commit_message();
      if (msg_count == 0) begin
        head_slot = '0;
        tail_slot = '0;
      end else begin
        head_slot = prev_slot(head_slot);
      end
      slot_pos[head_slot] = wr_base;
      slot_len[head_slot] = wr_len;
      msg_count++;
      wr_open = 1'b0;
      wr_left = '0;
    endfunction

    function void release_message();
      if (int'(free_cnt) + int'(slot_len[tail_slot]) > BUFFER_BYTES)
        free_cnt = FREE_W'(BUFFER_BYTES);
      else
        free_cnt = free_cnt + slot_len[tail_slot];
      if (msg_count > 0) msg_count--;
      if (msg_count == 0) begin
        head_slot = '0;
        tail_slot = '0;
      end else begin
        tail_slot = prev_slot(tail_slot);
      end
      rd_open = 1'b0;
      rd_left = '0;
    endfunction

    function void accept_word(item_t w);
      result_t r;
      r = '0;
      r.status = ST_OK;
      case (w.command)
        CMD_PUT_START: begin
          if (wr_open) begin
            r.status = ST_SEQUENCE;
          end else if (msg_count >= HEADER_SLOTS || free_cnt < w.message_length) begin
            r.status = ST_NO_SPACE;
          end else begin
            // Pack just below the newest message; an empty queue restarts at zero.
            if (msg_count == 0)
              wr_base = '0;
            else
              wr_base = PTR_W'((int'(slot_pos[head_slot]) + BUFFER_BYTES
                                - int'(w.message_length)) % BUFFER_BYTES);
            wr_len = w.message_length;
            free_cnt = free_cnt - w.message_length;
            wr_ptr = wr_base;
            wr_left = w.message_length;
            wr_open = 1'b1;
            if (w.message_length == 0) commit_message();
          end
        end
        CMD_PUT_BYTE: begin
          if (!wr_open) begin
            r.status = ST_SEQUENCE;
          end else begin
            store_bytes[wr_ptr] = w.data_byte;
            wr_ptr = next_pos(wr_ptr);
            if (wr_left > 0) wr_left--;
            if (wr_left == 0) begin
              r.last_byte = 1'b1;
              commit_message();
            end
          end
        end
        CMD_GET_BYTE: begin
          if (!rd_open && msg_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (!rd_open) begin
              rd_ptr = slot_pos[tail_slot];
              rd_left = slot_len[tail_slot];
              rd_open = 1'b1;
            end
            r.oldest_length = slot_len[tail_slot];
            if (rd_left != 0) begin
              r.read_byte = store_bytes[rd_ptr];
              rd_ptr = next_pos(rd_ptr);
              rd_left--;
            end
            // A zero-length message is released by the same word that opens it.
            if (rd_left == 0) begin
              r.last_byte = 1'b1;
              release_message();
            end
          end
        end
        CMD_PEEK: begin
          if (msg_count == 0) r.status = ST_EMPTY;
          else r.oldest_length = slot_len[tail_slot];
        end
        CMD_ERASE: begin
          head_slot = '0;
          tail_slot = '0;
          msg_count = '0;
          free_cnt = FREE_W'(BUFFER_BYTES);
          wr_ptr = '0;
          wr_left = '0;
          wr_open = 1'b0;
          rd_ptr = '0;
          rd_left = '0;
          rd_open = 1'b0;
        end
        default: r.status = ST_SEQUENCE;
      endcase
      r.message_count = msg_count;
      r.bytes_free = free_cnt;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("word %0d %s: got %0h, expected %0h", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0h with nothing outstanding", got));
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 16'(got.status), 16'(want.status));
        compare_field("read_byte", 16'(got.read_byte), 16'(want.read_byte));
        compare_field("last_byte", 16'(got.last_byte), 16'(want.last_byte));
        compare_field("oldest_length", 16'(got.oldest_length), 16'(want.oldest_length));
        compare_field("message_count", 16'(got.message_count), 16'(want.message_count));
        compare_field("bytes_free", 16'(got.bytes_free), 16'(want.bytes_free));
        checked++;
      end
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  msg_fifo_scoreboard sb = new();
  int unsigned burst_left;
  int unsigned sent;
  int unsigned idle_cycles;

  variable_length_message_fifo_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check before noting: a word accepted at this edge cannot have its result yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.accept_word(item);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("variable_length_message_fifo_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Enter and leave at a falling edge. Start stays high through a burst.
  task automatic send_word(input logic [2:0] cmd, input logic [LEN_W-1:0] len,
                           input logic [7:0] data);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) < 3) ? 10 : 3)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    start = 1'b1;
    item = '{command: cmd, message_length: len, data_byte: data};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd <= CMD_ERASE) sent++;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned k;
    logic [LEN_W-1:0] len;
    bit filling;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    burst_left = 0;
    sent = 0;
    idle_cycles = 0;
    filling = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty-queue and out-of-sequence corners.
    send_word(CMD_PEEK, 11'd0, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    send_word(CMD_PUT_BYTE, 11'd0, 8'hFF);
    send_word(CMD_SPARE_LO, 11'h7FF, 8'hFF);
    send_word(CMD_SPARE_HI, 11'h000, 8'h00);
    send_word(CMD_PUT_START, 11'h7FF, 8'h00);
    // Zero-length message goes in and comes out as a single word.
    send_word(CMD_PUT_START, 11'd0, 8'h00);
    send_word(CMD_PEEK, 11'd0, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    // Reserve the whole store, collide, then erase mid-put.
    send_word(CMD_PUT_START, LEN_W'(BUFFER_BYTES), 8'h00);
    send_word(CMD_PUT_START, 11'd3, 8'h00);
    send_word(CMD_ERASE, 11'd0, 8'h00);
    send_word(CMD_PUT_START, 11'd3, 8'h00);
    send_word(CMD_PUT_BYTE, 11'd0, 8'h00);
    send_word(CMD_PUT_BYTE, 11'd0, 8'hFF);
    send_word(CMD_PUT_BYTE, 11'd0, 8'h5A);
    // Read while a put runs; the queue drains before that put commits.
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    send_word(CMD_PUT_START, 11'd2, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    send_word(CMD_PUT_BYTE, 11'd0, 8'h81);
    send_word(CMD_PUT_BYTE, 11'd0, 8'h7E);
    send_word(CMD_PEEK, 11'd0, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    send_word(CMD_GET_BYTE, 11'd0, 8'h00);
    wait_drained();
    sent = 0;

    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_word(3'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 2047)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        send_word(CMD_ERASE, LEN_W'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
      end else if (pick < 9) begin
        send_word(CMD_PEEK, LEN_W'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
      end else if (pick == 9) begin
        wait_drained();
      end else if (pick < (filling ? 70 : 30)) begin
        // Mostly short messages, a few long ones, now and then too long to fit.
        k = $urandom_range(0, 99);
        if (k < 8) len = '0;
        else if (k < 80) len = LEN_W'($urandom_range(1, 8));
        else if (k < 95) len = LEN_W'($urandom_range(9, 40));
        else if (k < 98) len = LEN_W'($urandom_range(41, 200));
        else len = LEN_W'($urandom_range(int'(sb.free_cnt) + 1, 2047));
        send_word(CMD_PUT_START, len, 8'($urandom_range(0, 255)));
        while (sb.wr_open) begin
          k = $urandom_range(0, 99);
          if (k < 10)
            send_word(CMD_GET_BYTE, LEN_W'($urandom_range(0, 2047)),
                      8'($urandom_range(0, 255)));
          else if (k < 12)
            send_word(CMD_PUT_START, LEN_W'($urandom_range(0, 2047)), 8'h00);
          else if (k == 12)
            send_word(CMD_ERASE, 11'd0, 8'h00);
          else
            send_word(CMD_PUT_BYTE, LEN_W'($urandom_range(0, 2047)),
                      8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 12))
          send_word(CMD_GET_BYTE, LEN_W'($urandom_range(0, 2047)),
                    8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("variable_length_message_fifo_top_tb: PASS");
    end else begin
      $display("variable_length_message_fifo_top_tb: FAIL");
    end
    $finish;
  end

endmodule
